>>> rtl/rhb_pkg.sv
package rhb_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TEMP_W  = 11;
  localparam int unsigned PULSE_W = 10;
  localparam int unsigned RESP_W  = 10;
  localparam int unsigned GLUC_W  = 11;
  localparam int unsigned SYS_W   = 10;
  localparam int unsigned DIA_W   = 10;

  // Default number of records held.
  localparam int unsigned DEPTH_DEF = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED = 3'd1;
  localparam logic [STAT_W-1:0] ST_DELETED = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFND  = 3'd3;
  localparam logic [STAT_W-1:0] ST_RECORD  = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [STAMP_W-1:0] stamp_secs;
    logic [TEMP_W-1:0]  temp_tenths_f;
    logic [PULSE_W-1:0] pulse_bpm;
    logic [RESP_W-1:0]  resp_rate;
    logic [GLUC_W-1:0]  glucose_level;
    logic [SYS_W-1:0]   systolic_mmhg;
    logic [DIA_W-1:0]   diastolic_mmhg;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   entry_index;
    logic [CNT_W-1:0]   entry_count;
    logic [STAMP_W-1:0] out_stamp;
    logic [TEMP_W-1:0]  out_temp;
    logic [PULSE_W-1:0] out_pulse;
    logic [RESP_W-1:0]  out_resp;
    logic [GLUC_W-1:0]  out_glucose;
    logic [SYS_W-1:0]   out_systolic;
    logic [DIA_W-1:0]   out_diastolic;
    logic               last;
  } out_item_t;

  // One stored record.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [TEMP_W-1:0]  temp;
    logic [PULSE_W-1:0] pulse;
    logic [RESP_W-1:0]  resp;
    logic [GLUC_W-1:0]  glucose;
    logic [SYS_W-1:0]   systolic;
    logic [DIA_W-1:0]   diastolic;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_cur;
    logic rd_next;
    logic wr_shift;
    logic inc;
    logic mark;
    logic add;
    logic del_done;
    logic emit_nf;
    logic emit_empty;
    logic emit_rec;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_end;
    logic next_end;
    logic match;
    logic empty;
  } dp_stat_t;

endpackage

>>> rtl/rhb_ctrl.sv
module rhb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rhb_pkg::OP_W-1:0]    op,
  input  rhb_pkg::dp_stat_t           stat,
  output rhb_pkg::dp_cmd_t            cmd,
  output logic                        busy
);

  rhb_pkg::state_t state;
  rhb_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rhb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      rhb_pkg::S_IDLE: begin
        if (start) begin
          case (op)
            rhb_pkg::OP_ADD:  state_next = rhb_pkg::S_ADD;
            rhb_pkg::OP_DEL:  state_next = rhb_pkg::S_SRCH_RD;
            rhb_pkg::OP_DUMP: state_next = rhb_pkg::S_DUMP_RD;
            default:          state_next = rhb_pkg::S_IDLE;
          endcase
        end
      end
      rhb_pkg::S_ADD: state_next = rhb_pkg::S_IDLE;
      rhb_pkg::S_SRCH_RD: begin
        state_next = stat.idx_end ? rhb_pkg::S_IDLE : rhb_pkg::S_SRCH_CMP;
      end
      rhb_pkg::S_SRCH_CMP: begin
        state_next = stat.match ? rhb_pkg::S_SHIFT_RD : rhb_pkg::S_SRCH_RD;
      end
      rhb_pkg::S_SHIFT_RD: begin
        state_next = stat.next_end ? rhb_pkg::S_IDLE : rhb_pkg::S_SHIFT_WR;
      end
      rhb_pkg::S_SHIFT_WR: state_next = rhb_pkg::S_SHIFT_RD;
      rhb_pkg::S_DUMP_RD: begin
        state_next = stat.idx_end ? rhb_pkg::S_IDLE : rhb_pkg::S_DUMP_OUT;
      end
      rhb_pkg::S_DUMP_OUT: begin
        state_next = stat.next_end ? rhb_pkg::S_IDLE : rhb_pkg::S_DUMP_RD;
      end
      default: state_next = rhb_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd  = '0;
    busy = (state != rhb_pkg::S_IDLE);
    case (state)
      rhb_pkg::S_IDLE:     cmd.load = start;
      rhb_pkg::S_ADD:      cmd.add = 1'b1;
      rhb_pkg::S_SRCH_RD: begin
        cmd.emit_nf = stat.idx_end;
        cmd.rd_cur  = !stat.idx_end;
      end
      rhb_pkg::S_SRCH_CMP: begin
        cmd.mark = stat.match;
        cmd.inc  = !stat.match;
      end
      rhb_pkg::S_SHIFT_RD: begin
        cmd.del_done = stat.next_end;
        cmd.rd_next  = !stat.next_end;
      end
      rhb_pkg::S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.inc      = 1'b1;
      end
      rhb_pkg::S_DUMP_RD: begin
        cmd.emit_empty = stat.empty;
        cmd.rd_cur     = !stat.idx_end;
      end
      rhb_pkg::S_DUMP_OUT: begin
        cmd.emit_rec = 1'b1;
        cmd.inc      = !stat.next_end;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/rhb_dpath.sv
module rhb_dpath #(
  parameter int unsigned DEPTH = rhb_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rhb_pkg::in_item_t    item,
  input  rhb_pkg::dp_cmd_t     cmd,
  output rhb_pkg::dp_stat_t    stat,
  output logic                 strobe,
  output rhb_pkg::out_item_t   result
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Circular store: logical position i lives at (head + i) mod DEPTH.
  rhb_pkg::rec_t mem [DEPTH];
  rhb_pkg::rec_t rec_in;
  rhb_pkg::rec_t rdata;

  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] found;

  logic          full;
  logic [CW-1:0] rd_off;
  logic [CW-1:0] wr_off;
  logic [CW:0]   rd_sum;
  logic [CW:0]   wr_sum;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic          wr_en;
  rhb_pkg::rec_t wdata;
  logic [CW:0]   idx_p1;
  logic          emit;
  rhb_pkg::out_item_t result_next;

  assign full   = (count == CW'(DEPTH));
  assign idx_p1 = {1'b0, idx} + (CW+1)'(1);
  assign emit   = cmd.add || cmd.del_done || cmd.emit_nf || cmd.emit_empty ||
                  cmd.emit_rec;

  // Status toward the controller.
  assign stat.idx_end  = (idx == count);
  assign stat.next_end = (idx_p1 >= {1'b0, count});
  assign stat.match    = (rdata.stamp == rec_in.stamp);
  assign stat.empty    = (count == '0);

  // Logical-to-physical address mapping, one compare and subtract each.
  always_comb begin
    rd_off = cmd.rd_next ? idx_p1[CW-1:0] : idx;
    wr_off = cmd.add ? count : idx;
    rd_sum = {{(CW+1-IW){1'b0}}, head} + {1'b0, rd_off};
    wr_sum = {{(CW+1-IW){1'b0}}, head} + {1'b0, wr_off};
    if (rd_sum >= (CW+1)'(DEPTH)) begin
      rd_sum = rd_sum - (CW+1)'(DEPTH);
    end
    if (wr_sum >= (CW+1)'(DEPTH)) begin
      wr_sum = wr_sum - (CW+1)'(DEPTH);
    end
    raddr = rd_sum[IW-1:0];
    waddr = wr_sum[IW-1:0];
    wr_en = cmd.add || cmd.wr_shift;
    wdata = cmd.add ? rec_in : rdata;
  end

  // Record memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Record memory read port, registered.
  always_ff @(posedge clk) begin
    if (cmd.rd_cur || cmd.rd_next) begin
      rdata <= mem[raddr];
    end
  end

  // Captured input item and the index of the matching record.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec_in.stamp     <= item.stamp_secs;
      rec_in.temp      <= item.temp_tenths_f;
      rec_in.pulse     <= item.pulse_bpm;
      rec_in.resp      <= item.resp_rate;
      rec_in.glucose   <= item.glucose_level;
      rec_in.systolic  <= item.systolic_mmhg;
      rec_in.diastolic <= item.diastolic_mmhg;
    end
    if (cmd.mark) begin
      found <= idx;
    end
  end

  // Head, fill count and walk index.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.inc) begin
        idx <= idx_p1[CW-1:0];
      end
      if (cmd.add) begin
        if (full) begin
          head <= (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.del_done) begin
        count <= count - CW'(1);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  // Next result; record fields stay zero except for dumped records.
  always_comb begin
    result_next      = '0;
    result_next.last = 1'b1;
    if (cmd.add) begin
      result_next.status      = full ? rhb_pkg::ST_DROPPED : rhb_pkg::ST_ADDED;
      result_next.entry_count = full ? rhb_pkg::CNT_W'(count)
                                     : rhb_pkg::CNT_W'(count + CW'(1));
    end else if (cmd.del_done) begin
      result_next.status      = rhb_pkg::ST_DELETED;
      result_next.entry_index = rhb_pkg::IDX_W'(found);
      result_next.entry_count = rhb_pkg::CNT_W'(count - CW'(1));
    end else if (cmd.emit_nf) begin
      result_next.status      = rhb_pkg::ST_NOTFND;
      result_next.entry_count = rhb_pkg::CNT_W'(count);
    end else if (cmd.emit_empty) begin
      result_next.status      = rhb_pkg::ST_EMPTY;
      result_next.entry_count = rhb_pkg::CNT_W'(count);
    end else begin
      result_next.status        = rhb_pkg::ST_RECORD;
      result_next.entry_index   = rhb_pkg::IDX_W'(idx);
      result_next.entry_count   = rhb_pkg::CNT_W'(count);
      result_next.out_stamp     = rdata.stamp;
      result_next.out_temp      = rdata.temp;
      result_next.out_pulse     = rdata.pulse;
      result_next.out_resp      = rdata.resp;
      result_next.out_glucose   = rdata.glucose;
      result_next.out_systolic  = rdata.systolic;
      result_next.out_diastolic = rdata.diastolic;
      result_next.last          = stat.next_end;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/record_history_buffer.sv
// Add: the single result is strobed from the result register after the add state that follows acceptance.
// Delete: each record searched is read then compared, and each record after the match is read then written down.
// Dump: each record is read through the registered memory read port, then issued before the next is read.
// Busy stays high until the final result is issued; results cannot be stalled.
// Synchronous reset empties the store at once (fill count and head cleared, no clearing pass).
module record_history_buffer #(
  parameter int unsigned DEPTH = rhb_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rhb_pkg::in_item_t   item,
  output logic                strobe,
  output rhb_pkg::out_item_t  result
);

  rhb_pkg::dp_cmd_t  cmd;
  rhb_pkg::dp_stat_t stat;

  rhb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rhb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

  // A result that is not the final one means the item is still being worked on.
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> busy)
    else $error("non-final result while idle");

  // An add is followed by a final result, strobed after the add state that follows acceptance.
  a_add_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == rhb_pkg::OP_ADD) |=> ##1 (strobe && result.last))
    else $error("add result missing");

  // An empty report always carries a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == rhb_pkg::ST_EMPTY) |-> (result.entry_count == '0))
    else $error("empty result with nonzero count");

endmodule

>>> tb/tb.sv
module tb;

  localparam int unsigned NREC = rhb_pkg::DEPTH_DEF;
  localparam logic [rhb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 100;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  rhb_pkg::in_item_t item;
  logic strobe;
  rhb_pkg::out_item_t result;

  // Predicted contents of the record store, oldest first.
  rhb_pkg::rec_t held_recs[NREC];
  int held_count;

  // Results predicted but not yet seen on the output.
  rhb_pkg::out_item_t pending_results[$];
  rhb_pkg::out_item_t want_res;

  int err_count;
  int stall_cycles;
  int ops_sent;
  bit quiet;

  record_history_buffer uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    end
  endtask

  // Compare one result with its prediction, field by field.
  task automatic check_result(rhb_pkg::out_item_t want, rhb_pkg::out_item_t got);
    check_field("status", want.status, got.status);
    check_field("entry_index", want.entry_index, got.entry_index);
    check_field("entry_count", want.entry_count, got.entry_count);
    check_field("out_stamp", want.out_stamp, got.out_stamp);
    check_field("out_temp", want.out_temp, got.out_temp);
    check_field("out_pulse", want.out_pulse, got.out_pulse);
    check_field("out_resp", want.out_resp, got.out_resp);
    check_field("out_glucose", want.out_glucose, got.out_glucose);
    check_field("out_systolic", want.out_systolic, got.out_systolic);
    check_field("out_diastolic", want.out_diastolic, got.out_diastolic);
    check_field("last", want.last, got.last);
  endtask

  // Update the predicted store for one accepted item and queue its results.
  task automatic apply_record_op(rhb_pkg::in_item_t it);
    rhb_pkg::out_item_t r;
    rhb_pkg::rec_t rec;
    int hit;
    r = '0;
    r.last = 1'b1;
    hit = -1;
    case (it.op)
      rhb_pkg::OP_ADD: begin
        rec.stamp = it.stamp_secs;
        rec.temp = it.temp_tenths_f;
        rec.pulse = it.pulse_bpm;
        rec.resp = it.resp_rate;
        rec.glucose = it.glucose_level;
        rec.systolic = it.systolic_mmhg;
        rec.diastolic = it.diastolic_mmhg;
        if (held_count == NREC) begin
          for (int i = 0; i < NREC - 1; i++) held_recs[i] = held_recs[i + 1];
          held_recs[NREC - 1] = rec;
          r.status = rhb_pkg::ST_DROPPED;
        end else begin
          held_recs[held_count] = rec;
          held_count++;
          r.status = rhb_pkg::ST_ADDED;
        end
        r.entry_count = rhb_pkg::CNT_W'(held_count);
        pending_results.push_back(r);
      end
      rhb_pkg::OP_DEL: begin
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && held_recs[i].stamp == it.stamp_secs) hit = i;
        end
        if (hit >= 0) begin
          for (int j = hit; j < held_count - 1; j++) held_recs[j] = held_recs[j + 1];
          held_count--;
          r.status = rhb_pkg::ST_DELETED;
          r.entry_index = rhb_pkg::IDX_W'(hit);
        end else begin
          r.status = rhb_pkg::ST_NOTFND;
        end
        r.entry_count = rhb_pkg::CNT_W'(held_count);
        pending_results.push_back(r);
      end
      rhb_pkg::OP_DUMP: begin
        if (held_count == 0) begin
          r.status = rhb_pkg::ST_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < held_count; i++) begin
            r.status = rhb_pkg::ST_RECORD;
            r.entry_index = rhb_pkg::IDX_W'(i);
            r.entry_count = rhb_pkg::CNT_W'(held_count);
            r.out_stamp = held_recs[i].stamp;
            r.out_temp = held_recs[i].temp;
            r.out_pulse = held_recs[i].pulse;
            r.out_resp = held_recs[i].resp;
            r.out_glucose = held_recs[i].glucose;
            r.out_systolic = held_recs[i].systolic;
            r.out_diastolic = held_recs[i].diastolic;
            r.last = (i == held_count - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: begin
        // The unused opcode leaves the store alone and gives no result.
      end
    endcase
  endtask

  // Present one item, wait for the block to take it, then predict it.
  task automatic send_item(rhb_pkg::in_item_t it);
    while (!quiet && $urandom_range(99) < 29) begin
      @(negedge clk);
      start = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    item = it;
    do @(posedge clk); while (busy);
    apply_record_op(it);
  endtask

  // Build an item with random vital signs.
  function automatic rhb_pkg::in_item_t vitals(logic [rhb_pkg::OP_W-1:0] op,
                                               logic [rhb_pkg::STAMP_W-1:0] stamp);
    rhb_pkg::in_item_t it;
    it.op = op;
    it.stamp_secs = stamp;
    it.temp_tenths_f = rhb_pkg::TEMP_W'($urandom);
    it.pulse_bpm = rhb_pkg::PULSE_W'($urandom);
    it.resp_rate = rhb_pkg::RESP_W'($urandom);
    it.glucose_level = rhb_pkg::GLUC_W'($urandom);
    it.systolic_mmhg = rhb_pkg::SYS_W'($urandom);
    it.diastolic_mmhg = rhb_pkg::DIA_W'($urandom);
    return it;
  endfunction

  // Dump and delete on an empty store, and the unused opcode.
  task automatic test_empty_store();
    rhb_pkg::in_item_t it;
    send_item(vitals(rhb_pkg::OP_DUMP, 32'd0));
    send_item(vitals(rhb_pkg::OP_DEL, 32'd0));
    it = '1;
    it.op = OP_UNUSED;
    send_item(it);
  endtask

  // Fill past capacity with extreme records and duplicate stamps, then dump.
  task automatic test_fill_and_overflow();
    logic [rhb_pkg::STAMP_W-1:0] stamps[9];
    rhb_pkg::in_item_t it;
    stamps = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd500, 32'd101,
               32'd500, 32'd102, 32'd103, 32'd104};
    for (int k = 0; k < 9; k++) begin
      if (k == 0) begin
        it = '0;
      end else if (k == 1) begin
        it = '1;
      end else begin
        it = vitals(rhb_pkg::OP_ADD, 32'd0);
      end
      it.op = rhb_pkg::OP_ADD;
      it.stamp_secs = stamps[k];
      send_item(it);
    end
    send_item(vitals(rhb_pkg::OP_DUMP, 32'd0));
  endtask

  // Delete the oldest of two duplicates, the oldest and newest records, a miss.
  task automatic test_delete_cases();
    send_item(vitals(rhb_pkg::OP_DEL, 32'd500));
    send_item(vitals(rhb_pkg::OP_DEL, 32'hFFFF_FFFF));
    send_item(vitals(rhb_pkg::OP_DEL, 32'd104));
    send_item(vitals(rhb_pkg::OP_DEL, 32'd12345));
    send_item(vitals(rhb_pkg::OP_DEL, 32'd500));
    send_item(vitals(rhb_pkg::OP_DUMP, 32'd0));
  endtask

  // Mixed traffic in blocks that lean toward filling or draining the store.
  task automatic test_random_traffic();
    int pick;
    int lean;
    int add_lim;
    int del_lim;
    logic [rhb_pkg::STAMP_W-1:0] key;
    ops_sent = 0;
    while (ops_sent < RAND_ITEMS) begin
      quiet = (ops_sent >= 40 && ops_sent < 75);
      lean = (ops_sent / 20) % 3;
      add_lim = (lean == 1) ? 70 : (lean == 2) ? 20 : 45;
      del_lim = (lean == 1) ? 80 : 75;
      pick = $urandom_range(99);
      if (pick < add_lim) begin
        key = ($urandom_range(3) == 0) ? $urandom : 32'd1000 + $urandom_range(15);
        send_item(vitals(rhb_pkg::OP_ADD, key));
        ops_sent++;
      end else if (pick < del_lim) begin
        if (held_count > 0 && $urandom_range(99) < 70) begin
          key = held_recs[$urandom_range(held_count - 1)].stamp;
        end else begin
          key = $urandom_range(1) ? $urandom : 32'd1000 + $urandom_range(15);
        end
        send_item(vitals(rhb_pkg::OP_DEL, key));
        ops_sent++;
      end else if (pick < 95) begin
        send_item(vitals(rhb_pkg::OP_DUMP, $urandom));
        ops_sent++;
      end else begin
        send_item(vitals(OP_UNUSED, $urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // Every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing pending");
      end else begin
        want_res = pending_results.pop_front();
        check_result(want_res, result);
      end
    end
  end

  // End the run if the block stops taking items.
  always @(posedge clk) begin
    if (rst || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    err_count = 0;
    stall_cycles = 0;
    held_count = 0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_store();
    test_fill_and_overflow();
    test_delete_cases();
    test_random_traffic();

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_count == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
